/* hdl/convex_polygon_sat_collision_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the convex polygon collision block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef CONVEX_POLYGON_SAT_COLLISION_MACROS_SVH
`define CONVEX_POLYGON_SAT_COLLISION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cps_pkg.sv */
// -----------------------------------------------------------------------------
// cps_pkg
// Types and constants shared by the controller and the datapath.
// -----------------------------------------------------------------------------
package cps_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_FEW = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // Datapath operations.
  localparam logic [4:0] OP_NOP    = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_CLR    = 5'd2;
  localparam logic [4:0] OP_CAP_PI = 5'd3;
  localparam logic [4:0] OP_EDGE   = 5'd4;
  localparam logic [4:0] OP_NORM   = 5'd5;
  localparam logic [4:0] OP_SQRT   = 5'd6;
  localparam logic [4:0] OP_DINIT  = 5'd7;
  localparam logic [4:0] OP_DSTEP  = 5'd8;
  localparam logic [4:0] OP_DEND   = 5'd9;
  localparam logic [4:0] OP_PMX    = 5'd10;
  localparam logic [4:0] OP_PMY    = 5'd11;
  localparam logic [4:0] OP_PUP    = 5'd12;
  localparam logic [4:0] OP_CMP    = 5'd13;
  localparam logic [4:0] OP_C1     = 5'd14;
  localparam logic [4:0] OP_C2     = 5'd15;
  localparam logic [4:0] OP_C3     = 5'd16;
  localparam logic [4:0] OP_RES    = 5'd17;

  // Iteration counts of the root and the quotient.
  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 15;

  typedef struct packed {
    logic [4:0] op;
    logic       sel;         // 0 = polygon A, 1 = polygon B
    logic       comp;        // 0 = x component, 1 = y component
    logic [1:0] res_status;
    logic       res_coll;
  } dp_cmd_t;

  typedef struct packed {
    logic rad_zero;
    logic separated;
  } dp_stat_t;

endpackage

/* hdl/cps_ram.sv */
// -----------------------------------------------------------------------------
// cps_ram
// Generic single write port, single read port RAM with registered read.
// -----------------------------------------------------------------------------
module cps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/cps_ctrl.sv */
// -----------------------------------------------------------------------------
// cps_ctrl
// Sequencer for loading, the axis loop, projections and the result.
// -----------------------------------------------------------------------------
`include "convex_polygon_sat_collision_macros.svh"

module cps_ctrl #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              in_action,
  input  logic                              in_last_vertex,
  output logic                              busy,
  output logic                              wr_a,
  output logic                              wr_b,
  output logic [$clog2(MAX_VERTICES)-1:0]   waddr,
  output logic [$clog2(MAX_VERTICES)-1:0]   raddr,
  output logic [$clog2(MAX_VERTICES+1)-1:0] cnt_a,
  output logic [$clog2(MAX_VERTICES+1)-1:0] cnt_b,
  output cps_pkg::dp_cmd_t                  cmd,
  input  cps_pkg::dp_stat_t                 st
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int IW = $clog2(MAX_VERTICES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_VERTICES);
  localparam logic [CW-1:0] MINC = CW'(3);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_EVAL  = 5'd1;
  localparam logic [4:0] S_ERA   = 5'd2;
  localparam logic [4:0] S_ERB   = 5'd3;
  localparam logic [4:0] S_EN    = 5'd4;
  localparam logic [4:0] S_ES    = 5'd5;
  localparam logic [4:0] S_ECHK  = 5'd6;
  localparam logic [4:0] S_SQ    = 5'd7;
  localparam logic [4:0] S_DINIT = 5'd8;
  localparam logic [4:0] S_DSTEP = 5'd9;
  localparam logic [4:0] S_DEND  = 5'd10;
  localparam logic [4:0] S_PRD   = 5'd11;
  localparam logic [4:0] S_PMX   = 5'd12;
  localparam logic [4:0] S_PMY   = 5'd13;
  localparam logic [4:0] S_PUP   = 5'd14;
  localparam logic [4:0] S_CMP   = 5'd15;
  localparam logic [4:0] S_C1    = 5'd16;
  localparam logic [4:0] S_C2    = 5'd17;
  localparam logic [4:0] S_C3    = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  logic [4:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic          ovf_r, ovf_nxt;
  logic          pa_r, pa_nxt, pp_r, pp_nxt, comp_r, comp_nxt;
  logic [CW-1:0] ei_r, ei_nxt, k_r, k_nxt;
  logic [4:0]    step_r, step_nxt;
  logic [1:0]    rstat_r, rstat_nxt;
  logic          rcoll_r, rcoll_nxt;

  logic          accept;
  logic [CW-1:0] n_src, n_proj, ei_inc, ej, k_inc;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign n_src  = pa_r ? cnt_b_r : cnt_a_r;
  assign n_proj = pp_r ? cnt_b_r : cnt_a_r;
  assign ei_inc = ei_r + CW'(1);
  assign k_inc  = k_r + CW'(1);
  assign ej     = (ei_inc == n_src) ? '0 : ei_inc;
  assign cnt_a  = cnt_a_r;
  assign cnt_b  = cnt_b_r;
  assign waddr  = in_action ? cnt_b_r[IW-1:0] : cnt_a_r[IW-1:0];

  always_comb begin
    unique case (state_r)
      S_ERA:   raddr = ei_r[IW-1:0];
      S_ERB:   raddr = ej[IW-1:0];
      default: raddr = k_r[IW-1:0];
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_a_nxt  = cnt_a_r;
    cnt_b_nxt  = cnt_b_r;
    ovf_nxt    = ovf_r;
    pa_nxt     = pa_r;
    pp_nxt     = pp_r;
    comp_nxt   = comp_r;
    ei_nxt     = ei_r;
    k_nxt      = k_r;
    step_nxt   = step_r;
    rstat_nxt  = rstat_r;
    rcoll_nxt  = rcoll_r;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    cmd        = '{op: cps_pkg::OP_NOP, sel: 1'b0, comp: 1'b0,
                   res_status: rstat_r, res_coll: rcoll_r};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.sel = in_action;
          if (in_action) begin
            if (cnt_b_r < MAXC) begin
              wr_b      = 1'b1;
              cnt_b_nxt = cnt_b_r + CW'(1);
              cmd.op    = cps_pkg::OP_LOAD;
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_last_vertex) begin
              state_nxt = S_EVAL;
            end
          end else begin
            if (cnt_a_r < MAXC) begin
              wr_a      = 1'b1;
              cnt_a_nxt = cnt_a_r + CW'(1);
              cmd.op    = cps_pkg::OP_LOAD;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      S_EVAL: begin
        rcoll_nxt = 1'b0;
        if (ovf_r) begin
          rstat_nxt = cps_pkg::ST_OVF;
          state_nxt = S_DONE;
        end else if (cnt_a_r < MINC || cnt_b_r < MINC) begin
          rstat_nxt = cps_pkg::ST_FEW;
          state_nxt = S_DONE;
        end else begin
          rstat_nxt = cps_pkg::ST_OK;
          cmd.op    = cps_pkg::OP_CLR;
          pa_nxt    = 1'b0;
          ei_nxt    = '0;
          state_nxt = S_ERA;
        end
      end
      S_ERA: begin
        state_nxt = S_ERB;
      end
      S_ERB: begin
        cmd.op    = cps_pkg::OP_CAP_PI;
        cmd.sel   = pa_r;
        state_nxt = S_EN;
      end
      S_EN: begin
        cmd.op    = cps_pkg::OP_EDGE;
        cmd.sel   = pa_r;
        state_nxt = S_ES;
      end
      S_ES: begin
        cmd.op    = cps_pkg::OP_NORM;
        state_nxt = S_ECHK;
      end
      S_ECHK: begin
        step_nxt = '0;
        if (!st.rad_zero) begin
          state_nxt = S_SQ;
        end else if (ei_inc != n_src) begin
          // A zero-length edge gives no axis: move on to the next edge.
          ei_nxt    = ei_inc;
          state_nxt = S_ERA;
        end else if (!pa_r) begin
          pa_nxt    = 1'b1;
          ei_nxt    = '0;
          state_nxt = S_ERA;
        end else begin
          state_nxt = S_C1;
        end
      end
      S_SQ: begin
        cmd.op   = cps_pkg::OP_SQRT;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(cps_pkg::SQRT_STEPS - 1)) begin
          comp_nxt  = 1'b0;
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.op    = cps_pkg::OP_DINIT;
        cmd.comp  = comp_r;
        step_nxt  = '0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op   = cps_pkg::OP_DSTEP;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(cps_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_DEND;
        end
      end
      S_DEND: begin
        cmd.op   = cps_pkg::OP_DEND;
        cmd.comp = comp_r;
        if (!comp_r) begin
          comp_nxt  = 1'b1;
          state_nxt = S_DINIT;
        end else begin
          pp_nxt    = 1'b0;
          k_nxt     = '0;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        state_nxt = S_PMX;
      end
      S_PMX: begin
        cmd.op    = cps_pkg::OP_PMX;
        cmd.sel   = pp_r;
        state_nxt = S_PMY;
      end
      S_PMY: begin
        cmd.op    = cps_pkg::OP_PMY;
        state_nxt = S_PUP;
      end
      S_PUP: begin
        cmd.op  = cps_pkg::OP_PUP;
        cmd.sel = pp_r;
        if (k_inc != n_proj) begin
          k_nxt     = k_inc;
          state_nxt = S_PRD;
        end else if (!pp_r) begin
          pp_nxt    = 1'b1;
          k_nxt     = '0;
          state_nxt = S_PRD;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.op = cps_pkg::OP_CMP;
        if (st.separated) begin
          rcoll_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (ei_inc != n_src) begin
          ei_nxt    = ei_inc;
          state_nxt = S_ERA;
        end else if (!pa_r) begin
          pa_nxt    = 1'b1;
          ei_nxt    = '0;
          state_nxt = S_ERA;
        end else begin
          state_nxt = S_C1;
        end
      end
      S_C1: begin
        cmd.op    = cps_pkg::OP_C1;
        state_nxt = S_C2;
      end
      S_C2: begin
        cmd.op    = cps_pkg::OP_C2;
        state_nxt = S_C3;
      end
      S_C3: begin
        cmd.op    = cps_pkg::OP_C3;
        rcoll_nxt = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.op    = cps_pkg::OP_RES;
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
      pa_r    <= 1'b0;
      pp_r    <= 1'b0;
      comp_r  <= 1'b0;
      ei_r    <= '0;
      k_r     <= '0;
      step_r  <= '0;
      rstat_r <= cps_pkg::ST_OK;
      rcoll_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      ovf_r   <= ovf_nxt;
      pa_r    <= pa_nxt;
      pp_r    <= pp_nxt;
      comp_r  <= comp_nxt;
      ei_r    <= ei_nxt;
      k_r     <= k_nxt;
      step_r  <= step_nxt;
      rstat_r <= rstat_nxt;
      rcoll_r <= rcoll_nxt;
    end
  end

  `CPS_ASSERT_NEXT(a_last_b_starts, accept && in_action && in_last_vertex, busy, "test did not start")
  `CPS_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_a_r <= MAXC && cnt_b_r <= MAXC, "count beyond capacity")
  `CPS_ASSERT_NEXT(a_done_clears, state_r == S_DONE, cnt_a_r == '0 && cnt_b_r == '0 && !ovf_r, "counts not cleared")

endmodule

/* hdl/cps_dp.sv */
// -----------------------------------------------------------------------------
// cps_dp
// Datapath: edge normals, integer root, axis division, projections, result.
// -----------------------------------------------------------------------------
module cps_dp #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cps_pkg::dp_cmd_t                  cmd,
  output cps_pkg::dp_stat_t                 st,
  input  logic [$clog2(MAX_VERTICES+1)-1:0] cnt_a,
  input  logic [$clog2(MAX_VERTICES+1)-1:0] cnt_b,
  input  logic signed [15:0]                in_vertex_x,
  input  logic signed [15:0]                in_vertex_y,
  input  logic [31:0]                       rdata_a,
  input  logic [31:0]                       rdata_b,
  output logic                              out_strobe,
  output logic [1:0]                        out_status,
  output logic                              out_colliding,
  output logic signed [15:0]                out_axis_x,
  output logic signed [15:0]                out_axis_y
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int SW = 16 + CW;          // vertex coordinate sums
  localparam int DW = SW + CW + 2;      // centroid direction
  localparam int TW = DW + 16;          // one term of the direction dot

  logic [31:0]        rsel;
  logic signed [15:0] rx, ry;

  logic signed [SW-1:0] sax_r, say_r, sbx_r, sby_r;
  logic signed [15:0]   pix_r, piy_r;
  logic signed [16:0]   nx_r, ny_r;
  logic [49:0]          rad_r;
  logic [27:0]          rem_r;
  logic [24:0]          root_r;
  logic [41:0]          dvd_r;
  logic [39:0]          dsh_r;
  logic [14:0]          q_r;
  logic                 clamp_r, neg_r;
  logic signed [15:0]   ax_r, ay_r;
  logic signed [31:0]   prod_r;
  logic signed [15:0]   vy_r;
  logic signed [32:0]   d_r;
  logic signed [32:0]   alo_r, ahi_r, blo_r, bhi_r;
  logic                 aseen_r, bseen_r;
  logic                 have_r;
  logic signed [33:0]   best_r;
  logic signed [15:0]   bx_r, by_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [TW-1:0] t_r;

  logic signed [33:0]   sqx, sqy;
  logic [33:0]          s_sum;
  logic [27:0]          rem2, trial;
  logic signed [16:0]   nsel;
  logic [16:0]          mag;
  logic [41:0]          dvd0;
  logic [25:0]          dsr;
  logic [14:0]          qv;
  logic signed [15:0]   qs;
  logic signed [32:0]   dterm;
  logic                 sep;
  logic signed [33:0]   ov;
  logic signed [CW:0]   ca_s, cb_s;
  logic signed [TW:0]   dot;

  assign rsel = cmd.sel ? rdata_b : rdata_a;
  assign rx   = rsel[15:0];
  assign ry   = rsel[31:16];

  assign sqx   = nx_r * nx_r;
  assign sqy   = ny_r * ny_r;
  assign s_sum = 34'(sqx) + 34'(sqy);

  assign rem2  = {rem_r[25:0], rad_r[49:48]};
  assign trial = {1'b0, root_r, 2'b01};

  assign nsel = cmd.comp ? ny_r : nx_r;
  assign mag  = nsel[16] ? 17'(-nsel) : 17'(nsel);
  assign dvd0 = {1'b0, mag, 24'd0} + 42'(root_r);
  assign dsr  = {root_r, 1'b0};

  assign qv = clamp_r ? 15'h7fff : q_r;
  assign qs = neg_r ? -$signed({1'b0, qv}) : $signed({1'b0, qv});

  assign dterm = 33'(prod_r) + 33'(ay_r * vy_r);

  assign sep = !(alo_r <= bhi_r && ahi_r >= blo_r);
  assign ov  = 34'(ahi_r < bhi_r ? ahi_r : bhi_r) - 34'(alo_r > blo_r ? alo_r : blo_r);

  assign ca_s = $signed({1'b0, cnt_a});
  assign cb_s = $signed({1'b0, cnt_b});
  assign dot  = (TW+1)'(t_r) + (TW+1)'(dy_r * by_r);

  assign st.rad_zero  = (rad_r == '0);
  assign st.separated = sep;

  // Sums and the output strobe are control state and take the reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sax_r      <= '0;
      say_r      <= '0;
      sbx_r      <= '0;
      sby_r      <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (cmd.op == cps_pkg::OP_RES);
      if (cmd.op == cps_pkg::OP_LOAD) begin
        if (cmd.sel) begin
          sbx_r <= sbx_r + SW'(in_vertex_x);
          sby_r <= sby_r + SW'(in_vertex_y);
        end else begin
          sax_r <= sax_r + SW'(in_vertex_x);
          say_r <= say_r + SW'(in_vertex_y);
        end
      end else if (cmd.op == cps_pkg::OP_RES) begin
        sax_r <= '0;
        say_r <= '0;
        sbx_r <= '0;
        sby_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      cps_pkg::OP_CLR: begin
        have_r <= 1'b0;
        bx_r   <= '0;
        by_r   <= '0;
      end
      cps_pkg::OP_CAP_PI: begin
        pix_r <= rx;
        piy_r <= ry;
      end
      cps_pkg::OP_EDGE: begin
        // Normal of e = p[i] - p[j] is (-ey, ex).
        nx_r <= 17'(ry) - 17'(piy_r);
        ny_r <= 17'(pix_r) - 17'(rx);
      end
      cps_pkg::OP_NORM: begin
        rad_r   <= {s_sum, 16'd0};
        rem_r   <= '0;
        root_r  <= '0;
        aseen_r <= 1'b0;
        bseen_r <= 1'b0;
      end
      cps_pkg::OP_SQRT: begin
        rad_r <= {rad_r[47:0], 2'b00};
        if (rem2 >= trial) begin
          rem_r  <= rem2 - trial;
          root_r <= {root_r[23:0], 1'b1};
        end else begin
          rem_r  <= rem2;
          root_r <= {root_r[23:0], 1'b0};
        end
      end
      cps_pkg::OP_DINIT: begin
        dvd_r   <= dvd0;
        dsh_r   <= {dsr, 14'd0};
        clamp_r <= (dvd0 >= {1'b0, dsr, 15'd0});
        neg_r   <= nsel[16];
        q_r     <= '0;
      end
      cps_pkg::OP_DSTEP: begin
        dsh_r <= {1'b0, dsh_r[39:1]};
        if (dvd_r >= {2'b00, dsh_r}) begin
          dvd_r <= dvd_r - {2'b00, dsh_r};
          q_r   <= {q_r[13:0], 1'b1};
        end else begin
          q_r <= {q_r[13:0], 1'b0};
        end
      end
      cps_pkg::OP_DEND: begin
        if (cmd.comp) begin
          ay_r <= qs;
        end else begin
          ax_r <= qs;
        end
      end
      cps_pkg::OP_PMX: begin
        prod_r <= ax_r * rx;
        vy_r   <= ry;
      end
      cps_pkg::OP_PMY: begin
        d_r <= dterm;
      end
      cps_pkg::OP_PUP: begin
        if (cmd.sel) begin
          bseen_r <= 1'b1;
          if (!bseen_r || d_r < blo_r) blo_r <= d_r;
          if (!bseen_r || d_r > bhi_r) bhi_r <= d_r;
        end else begin
          aseen_r <= 1'b1;
          if (!aseen_r || d_r < alo_r) alo_r <= d_r;
          if (!aseen_r || d_r > ahi_r) ahi_r <= d_r;
        end
      end
      cps_pkg::OP_CMP: begin
        // Ties keep the earlier axis.
        if (!sep && (!have_r || ov < best_r)) begin
          have_r <= 1'b1;
          best_r <= ov;
          bx_r   <= ax_r;
          by_r   <= ay_r;
        end
      end
      cps_pkg::OP_C1: begin
        dx_r <= DW'(sax_r * cb_s) - DW'(sbx_r * ca_s);
        dy_r <= DW'(say_r * cb_s) - DW'(sby_r * ca_s);
      end
      cps_pkg::OP_C2: begin
        t_r <= dx_r * bx_r;
      end
      cps_pkg::OP_C3: begin
        if (dot < 0) begin
          bx_r <= -bx_r;
          by_r <= -by_r;
        end
      end
      cps_pkg::OP_RES: begin
        out_status    <= cmd.res_status;
        out_colliding <= cmd.res_coll;
        out_axis_x    <= cmd.res_coll ? bx_r : 16'sd0;
        out_axis_y    <= cmd.res_coll ? by_r : 16'sd0;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/convex_polygon_sat_collision.sv */
// -----------------------------------------------------------------------------
// convex_polygon_sat_collision
// Separating axis collision test for two convex polygons, loaded vertex by
// vertex.
// -----------------------------------------------------------------------------
// Vertices of polygon A and polygon B are written one item per cycle while
// busy is low; an item is taken at a rising edge with start high and busy low.
// The item that carries the last vertex of B starts the test and raises busy
// until the single result has been produced. The result sits on the out_
// ports for exactly one cycle with out_strobe high and cannot be held off, so
// the receiver must take it in that cycle. Error answers (too few vertices or
// too many) pass from the evaluation state straight to the result state and
// its registered strobe. A full test is run by the controller one edge at a
// time: for each edge it fetches the two vertices, forms the normal and its
// squared length, takes the bit-serial root, runs the shared restoring divider
// once per component and walks both stores for the projections, then compares
// the spans. The evaluation step comes before the edges, the final centroid
// flip and the result after them. The vertex stores are two small RAMs with
// registered read, so a vertex fetch returns its data in the next cycle.
// -----------------------------------------------------------------------------
module convex_polygon_sat_collision #(
  parameter int MAX_VERTICES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic signed [15:0] in_vertex_x,
  input  logic signed [15:0] in_vertex_y,
  input  logic               in_last_vertex,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic               out_colliding,
  output logic signed [15:0] out_axis_x,
  output logic signed [15:0] out_axis_y
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int IW = $clog2(MAX_VERTICES);

  cps_pkg::dp_cmd_t  cmd;
  cps_pkg::dp_stat_t st;
  logic              wr_a, wr_b;
  logic [IW-1:0]     waddr, raddr;
  logic [CW-1:0]     cnt_a, cnt_b;
  logic [31:0]       wdata, rdata_a, rdata_b;

  // Stored vertex word: x in the low half, y in the high half.
  assign wdata = {in_vertex_y, in_vertex_x};

  cps_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_action      (in_action),
    .in_last_vertex (in_last_vertex),
    .busy           (busy),
    .wr_a           (wr_a),
    .wr_b           (wr_b),
    .waddr          (waddr),
    .raddr          (raddr),
    .cnt_a          (cnt_a),
    .cnt_b          (cnt_b),
    .cmd            (cmd),
    .st             (st)
  );

  // Both stores are read at the same address; the datapath picks one.
  cps_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram_a (
    .clk   (clk),
    .we    (wr_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  cps_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram_b (
    .clk   (clk),
    .we    (wr_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  cps_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .cnt_a         (cnt_a),
    .cnt_b         (cnt_b),
    .in_vertex_x   (in_vertex_x),
    .in_vertex_y   (in_vertex_y),
    .rdata_a       (rdata_a),
    .rdata_b       (rdata_b),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_colliding (out_colliding),
    .out_axis_x    (out_axis_x),
    .out_axis_y    (out_axis_y)
  );

endmodule

/* tb/tb_convex_polygon_sat_collision.sv */
// -----------------------------------------------------------------------------
// tb_convex_polygon_sat_collision
// Self-checking testbench for the separating axis polygon collision block.
// -----------------------------------------------------------------------------
// Polygons A and B are loaded vertex by vertex. A predictor written inside the
// bench mirrors the vertex stores and, on the last vertex of B, computes the
// status, collision flag and minimum-overlap axis. A monitor compares every
// strobed result with the oldest predicted answer. Stimulus is a directed set
// of error and geometry cases, then random well-formed polygon pairs with some
// broken sequences mixed in, under three sender idling profiles.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_convex_polygon_sat_collision;

  localparam int NV = 8;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]         status;
    logic               colliding;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_action = 1'b0;
  logic signed [15:0] in_vertex_x = '0;
  logic signed [15:0] in_vertex_y = '0;
  logic               in_last_vertex = 1'b0;
  logic               out_strobe;
  logic [1:0]         out_status;
  logic               out_colliding;
  logic signed [15:0] out_axis_x;
  logic signed [15:0] out_axis_y;

  convex_polygon_sat_collision #(.MAX_VERTICES(NV)) dut (.*);

  always #2 clk = ~clk;

  // Predictor state: a private copy of both vertex stores and counters.
  logic signed [15:0] pa_x [NV], pa_y [NV], pb_x [NV], pb_y [NV];
  int unsigned  cnt_a, cnt_b;
  bit           ovf_flag;
  answer_t      pending_answers[$];
  int           errors = 0;
  int           answers_seen = 0;
  int           collisions_seen = 0;
  int           send_idle_pct = 0;
  longint       cycle_count = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (answer %0d)", what, got, want,
             answers_seen);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Round-half-away quotient of one normal component, clamped to Q1.15.
  function automatic longint unit_comp(input longint n, input longint unsigned len);
    longint unsigned mag, q;
    mag = (n < 0) ? -n : n;
    q = ((mag << 24) + len) / (2 * len);
    if (q > 32767) q = 32767;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void span_of(input longint ax, input longint ay, input bit of_b,
                                  output longint lo, output longint hi);
    longint d;
    int unsigned n;
    n = of_b ? cnt_b : cnt_a;
    for (int i = 0; i < n; i++) begin
      d = of_b ? ax * pb_x[i] + ay * pb_y[i] : ax * pa_x[i] + ay * pa_y[i];
      if (i == 0 || d < lo) lo = d;
      if (i == 0 || d > hi) hi = d;
    end
  endfunction

  // Walks the edge normals of one polygon; returns 0 if one separates them.
  function automatic bit walk_edges(input bit of_b, inout bit have, inout longint best,
                                    inout longint bx, inout longint by);
    int unsigned n, j;
    longint ex, ey, ax, ay, alo, ahi, blo, bhi, ov;
    longint unsigned s, len;
    n = of_b ? cnt_b : cnt_a;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      ex = of_b ? longint'(pb_x[i]) - pb_x[j] : longint'(pa_x[i]) - pa_x[j];
      ey = of_b ? longint'(pb_y[i]) - pb_y[j] : longint'(pa_y[i]) - pa_y[j];
      s = ey * ey + ex * ex;
      if (s == 0) continue;
      len = int_sqrt(s << 16);
      ax = unit_comp(-ey, len);
      ay = unit_comp(ex, len);
      span_of(ax, ay, 1'b0, alo, ahi);
      span_of(ax, ay, 1'b1, blo, bhi);
      if (!(alo <= bhi && ahi >= blo)) return 1'b0;
      ov = ((ahi < bhi) ? ahi : bhi) - ((alo > blo) ? alo : blo);
      if (!have || ov < best) begin
        have = 1'b1;
        best = ov;
        bx = ax;
        by = ay;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_vertex(input bit act, input logic signed [15:0] x,
                                         input logic signed [15:0] y, input bit last);
    answer_t r;
    bit have;
    longint best, bx, by, sax, say, sbx, sby, dx, dy;
    if (act) begin
      if (cnt_b < NV) begin
        pb_x[cnt_b] = x;
        pb_y[cnt_b] = y;
        cnt_b++;
      end else ovf_flag = 1'b1;
    end else begin
      if (cnt_a < NV) begin
        pa_x[cnt_a] = x;
        pa_y[cnt_a] = y;
        cnt_a++;
      end else ovf_flag = 1'b1;
    end
    if (!act || !last) return;
    r = '{cps_pkg::ST_OK, 1'b0, 16'sd0, 16'sd0};
    bx = 0;
    by = 0;
    if (ovf_flag) r.status = cps_pkg::ST_OVF;
    else if (cnt_a < 3 || cnt_b < 3) r.status = cps_pkg::ST_FEW;
    else begin
      have = 1'b0;
      best = 0;
      if (walk_edges(1'b0, have, best, bx, by) && walk_edges(1'b1, have, best, bx, by)) begin
        sax = 0; say = 0; sbx = 0; sby = 0;
        for (int i = 0; i < cnt_a; i++) begin
          sax += pa_x[i];
          say += pa_y[i];
        end
        for (int i = 0; i < cnt_b; i++) begin
          sbx += pb_x[i];
          sby += pb_y[i];
        end
        dx = sax * cnt_b - sbx * cnt_a;
        dy = say * cnt_b - sby * cnt_a;
        if (dx * bx + dy * by < 0) begin
          bx = -bx;
          by = -by;
        end
        r.colliding = 1'b1;
        r.axis_x = bx[15:0];
        r.axis_y = by[15:0];
      end
    end
    cnt_a = 0;
    cnt_b = 0;
    ovf_flag = 1'b0;
    pending_answers.insert(pending_answers.size(), r);
  endfunction

  // Drives one item from a falling edge and holds it until it is taken.
  // Start stays high into the next call unless the sender idles first.
  task automatic send_vertex(input bit act, input logic signed [15:0] x,
                             input logic signed [15:0] y, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_vertex_x <= x;
    in_vertex_y <= y;
    in_last_vertex <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_vertex(act, x, y, last);
    @(negedge clk);
  endtask

  // Waits for every pending answer, then lets the datapath settle.
  task automatic drain_answers();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Regular polygon with n corners, counter-clockwise, around (cx, cy).
  task automatic send_polygon(input bit act, input int n, input int cx, input int cy,
                              input int rad, input real phase, input bit mark_last);
    real ang;
    for (int i = 0; i < n; i++) begin
      ang = phase + 6.283185307 * i / n;
      send_vertex(act, 16'(cx + $rtoi(rad * $cos(ang))), 16'(cy + $rtoi(rad * $sin(ang))),
                  mark_last && (i == n - 1));
    end
  endtask

  task automatic test_directed();
    // Too few vertices in A, then in B.
    send_polygon(1'b0, 2, 0, 0, 100, 0.0, 1'b1);
    send_polygon(1'b1, 3, 0, 0, 100, 0.0, 1'b1);
    send_polygon(1'b0, 3, 0, 0, 100, 0.0, 1'b1);
    send_polygon(1'b1, 1, 0, 0, 100, 0.0, 1'b1);
    // Over capacity in A (also under three in B: overflow must win).
    send_polygon(1'b0, 9, 0, 0, 100, 0.0, 1'b0);
    send_vertex(1'b1, 16'sh7FFF, 16'sh8000, 1'b1);
    // Overlapping triangles at extreme coordinates.
    send_vertex(1'b0, 16'sh8000, 16'sh8000, 1'b0);
    send_vertex(1'b0, 16'sh7FFF, 16'sh8000, 1'b0);
    send_vertex(1'b0, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_vertex(1'b1, 16'sh8000, 16'sh7FFF, 1'b0);
    send_vertex(1'b1, 16'sh8000, 16'sh8000, 1'b0);
    send_vertex(1'b1, 16'sh7FFF, 16'sh7FFF, 1'b1);
    drain_answers();
    // All-degenerate edges: every vertex the same point gives no axis.
    repeat (3) send_vertex(1'b0, 16'sd5, -16'sd5, 1'b0);
    repeat (2) send_vertex(1'b1, 16'sd5, -16'sd5, 1'b0);
    send_vertex(1'b1, 16'sd5, -16'sd5, 1'b1);
    // Separated polygons.
    send_polygon(1'b0, 4, -3000, 0, 800, 0.0, 1'b1);
    send_polygon(1'b1, 4, 3000, 0, 800, 0.0, 1'b1);
    drain_answers();
  endtask

  task automatic test_random(input int items);
    int sent, na, nb, kind;
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(19);
      na = (kind == 0) ? $urandom_range(10) : $urandom_range(NV, 3);
      nb = (kind == 1) ? $urandom_range(10, 1) : $urandom_range(NV, 3);
      if (kind == 2) begin
        // Noise: raw vertices with random fields, any flags.
        repeat (4) send_vertex($urandom_range(1), 16'($urandom), 16'($urandom),
                               $urandom_range(1));
        sent += 4;
      end else begin
        if ($urandom_range(3) == 0)
          send_polygon(1'b0, na, int'($urandom_range(4000)) - 2000,
                       int'($urandom_range(4000)) - 2000, $urandom_range(9000, 1),
                       $urandom_range(628) / 100.0, $urandom_range(1));
        else
          send_polygon(1'b0, na, int'($urandom_range(60000)) - 30000,
                       int'($urandom_range(60000)) - 30000, $urandom_range(2500, 0),
                       $urandom_range(628) / 100.0, $urandom_range(1));
        send_polygon(1'b1, nb, int'($urandom_range(4000)) - 2000,
                     int'($urandom_range(4000)) - 2000, $urandom_range(9000, 1),
                     $urandom_range(628) / 100.0, 1'b1);
        sent += na + nb;
      end
    end
  endtask

  // Results cannot be held off, so each strobe is checked where it stands.
  always @(posedge clk) begin
    answer_t w;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result", out_status, -1);
      end else begin
        w = pending_answers.pop_front();
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_colliding !== w.colliding)
          report_mismatch("colliding", out_colliding, w.colliding);
        if (out_axis_x !== w.axis_x) report_mismatch("axis_x", out_axis_x, w.axis_x);
        if (out_axis_y !== w.axis_y) report_mismatch("axis_y", out_axis_y, w.axis_y);
        if (w.colliding) collisions_seen++;
      end
      answers_seen++;
    end
  end

  initial begin
    cnt_a = 0;
    cnt_b = 0;
    ovf_flag = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    send_idle_pct = 25;
    test_random(350);
    drain_answers();
    send_idle_pct = 64;
    test_random(350);
    drain_answers();
    send_idle_pct = 0;
    test_random(350);
    drain_answers();
    repeat (20) @(negedge clk);
    if (pending_answers.size() != 0)
      report_mismatch("answers left over", pending_answers.size(), 0);
    $display("covered %0d results, %0d colliding, error and degenerate cases",
             answers_seen, collisions_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
